[design/b64d_pkg.sv]
// Shared types, character codes and the alphabet lookup for the Base64 stream decoder.
`timescale 1ns / 1ps

package b64d_pkg;

    // Character codes that steer the quartet sequence
    localparam logic [7:0] CHR_CR  = 8'h0D;
    localparam logic [7:0] CHR_LF  = 8'h0A;
    localparam logic [7:0] CHR_PAD = 8'h3D;

    // Default depth of the queue between front and back
    localparam int FIFO_DEPTH_DEFAULT = 2;

    // Work handed from the front to the back
    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,  // first character: keep its sextet
        OP_BYTE1 = 2'd1,  // second character: first byte of the quartet
        OP_BYTE2 = 2'd2,  // third character: second byte
        OP_BYTE3 = 2'd3   // fourth character: third byte
    } op_code_t;

    typedef struct packed {
        op_code_t   op;
        logic [5:0] sextet;
    } op_t;

    // Status the front reports to the top level
    typedef struct packed {
        logic at_start;  // next character opens a quartet
    } front_stat_t;

    // Map one ASCII code to its 6-bit value; anything outside the alphabet gives 0
    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [5:0] s;
        s = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s = 6'd62;
        end else if (c == 8'h2F) begin
            s = 6'd63;
        end
        return s;
    endfunction

endpackage

[design/base64_stream_decoder.sv]
// Top level of the Base64 stream decoder: front end, operation queue and back end.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------------
//  input   | in_valid / in_ready  | text_char, final_char
//  output  | out_valid / out_ready| out_byte
//
// One character is accepted every cycle while the operation queue has room.
// A byte reaches the output by way of the operation queue and the output register.
// The front end (quartet position) and the back end (held sextet, output
// register) are parted by a FIFO_DEPTH entry queue, so an output stall only
// stops input once that queue fills. Reset clears the quartet position, the
// queue, the held sextet and the output valid; nothing else needs clearing.
`timescale 1ns / 1ps

module base64_stream_decoder #(
    parameter int FIFO_DEPTH = b64d_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_char,
    input  logic       final_char,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte
);
    import b64d_pkg::*;

    logic        accept;
    logic        fifo_push;
    op_t         fifo_push_op;
    logic        fifo_pop;
    op_t         fifo_head_op;
    logic        fifo_empty;
    logic        fifo_full;
    front_stat_t front_stat;

    assign in_ready = !fifo_full;
    assign accept   = in_valid && in_ready;

    b64d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .text_char  (text_char),
        .final_char (final_char),
        .push       (fifo_push),
        .push_op    (fifo_push_op),
        .stat       (front_stat)
    );

    b64d_fifo #(
        .Depth (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fifo_push),
        .push_op (fifo_push_op),
        .pop     (fifo_pop),
        .head_op (fifo_head_op),
        .empty   (fifo_empty),
        .full    (fifo_full)
    );

    b64d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_op    (fifo_head_op),
        .head_valid (!fifo_empty),
        .pop        (fifo_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte)
    );

    // The front never issues into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push |-> !fifo_full)
        else $error("operation pushed into full queue");

    // A last character returns the front to quartet start
    a_final_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && final_char) |=> front_stat.at_start)
        else $error("quartet position not cleared after last character");

    // A byte operation at the head leaves the queue whenever the output slot is free
    a_back_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (!fifo_empty && (!out_valid || out_ready)) |-> fifo_pop)
        else $error("back end stalled with free output slot");

endmodule

[design/b64d_front.sv]
// Front end: accepts characters, tracks the quartet position and issues decode operations.
`timescale 1ns / 1ps

module b64d_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           text_char,
    input  logic                 final_char,
    output logic                 push,
    output b64d_pkg::op_t        push_op,
    output b64d_pkg::front_stat_t stat
);
    import b64d_pkg::*;

    typedef enum logic [4:0] {
        ST_Q0   = 5'b00001,
        ST_Q1   = 5'b00010,
        ST_Q2   = 5'b00100,
        ST_Q3   = 5'b01000,
        ST_SKIP = 5'b10000
    } front_state_t;

    front_state_t state_reg;
    front_state_t state_next;
    logic         is_newline;
    logic         is_pad;

    assign is_newline = (text_char == CHR_CR) || (text_char == CHR_LF);
    assign is_pad     = (text_char == CHR_PAD);

    // Classify the character against the quartet position
    always_comb
    begin
        state_next     = state_reg;
        push           = 1'b0;
        push_op.op     = OP_HOLD;
        push_op.sextet = sextet_of(text_char);
        if (accept)
        begin
            unique case (state_reg)
                ST_Q0:
                begin
                    if (!is_newline)
                    begin
                        push       = 1'b1;
                        push_op.op = OP_HOLD;
                        state_next = ST_Q1;
                    end
                end
                ST_Q1:
                begin
                    push       = 1'b1;
                    push_op.op = OP_BYTE1;
                    state_next = ST_Q2;
                end
                ST_Q2:
                begin
                    if (is_pad)
                    begin
                        state_next = ST_SKIP;
                    end
                    else
                    begin
                        push       = 1'b1;
                        push_op.op = OP_BYTE2;
                        state_next = ST_Q3;
                    end
                end
                ST_Q3:
                begin
                    if (!is_pad)
                    begin
                        push       = 1'b1;
                        push_op.op = OP_BYTE3;
                    end
                    state_next = ST_Q0;
                end
                ST_SKIP:
                begin
                    state_next = ST_Q0;
                end
                default:
                begin
                    state_next = ST_Q0;
                end
            endcase
            // Drop back to quartet start after the last character
            if (final_char)
            begin
                state_next = ST_Q0;
            end
        end
    end

    // Advance the quartet position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_Q0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign stat.at_start = (state_reg == ST_Q0);

endmodule

[design/b64d_fifo.sv]
// Short queue of decode operations between the front and the back.
`timescale 1ns / 1ps

module b64d_fifo #(
    parameter int Depth = b64d_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  b64d_pkg::op_t push_op,
    input  logic          pop,
    output b64d_pkg::op_t head_op,
    output logic          empty,
    output logic          full
);
    import b64d_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);

    op_t            mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CntW'(Depth));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head_op = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastIdx) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastIdx) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

[design/b64d_back.sv]
// Back end: joins held and new sextets into bytes and holds the output register.
`timescale 1ns / 1ps

module b64d_back (
    input  logic          clk,
    input  logic          rst_n,
    input  b64d_pkg::op_t head_op,
    input  logic          head_valid,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte
);
    import b64d_pkg::*;

    logic [5:0] prev_reg;
    logic [5:0] prev_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;
    logic       is_hold;

    assign slot_free = !out_valid_reg || out_ready;
    assign is_hold   = (head_op.op == OP_HOLD);
    assign pop       = head_valid && (is_hold || slot_free);

    // Build the byte for the operation at the head of the queue
    always_comb
    begin
        prev_next      = prev_reg;
        out_byte_next  = out_byte_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (pop)
        begin
            unique case (head_op.op)
                OP_HOLD:
                begin
                    prev_next = head_op.sextet;
                end
                OP_BYTE1:
                begin
                    out_byte_next  = {prev_reg, head_op.sextet[5:4]};
                    out_valid_next = 1'b1;
                    prev_next      = head_op.sextet;
                end
                OP_BYTE2:
                begin
                    out_byte_next  = {prev_reg[3:0], head_op.sextet[5:2]};
                    out_valid_next = 1'b1;
                    prev_next      = head_op.sextet;
                end
                OP_BYTE3:
                begin
                    out_byte_next  = {prev_reg[1:0], head_op.sextet};
                    out_valid_next = 1'b1;
                end
                default:
                begin
                    prev_next = prev_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the byte until the transaction completes
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

endmodule

[test/base64_stream_decoder_tb.sv]
// Self-checking testbench for the Base64 stream decoder: random text, bursty sender, stalls.
`timescale 1ns / 1ps

module base64_stream_decoder_tb;

    import b64d_pkg::*;

    localparam int  RANDOM_ITEMS      = 750;
    localparam int  DRAIN_MARK_AT     = 400;
    localparam int  HOLD_OFF_AFTER    = 120;
    localparam int  LONG_STALL_CYCLES = 300;
    localparam int  SETTLE_CYCLES     = 20;
    localparam real TIMEOUT_NS        = 2_000_000.0;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       wait_drain;
    } text_item_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] text_char = 8'h00;
    logic       final_char = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;

    text_item_t pending_chars[$];
    logic [7:0] expected_bytes[$];
    logic [5:0] sextet_lut[256];

    // decoder state as predicted
    logic [1:0] quartet_pos = 2'd0;
    logic [5:0] held_sextet = 6'd0;
    logic       skip_next = 1'b0;

    int  mismatch_count = 0;
    int  chars_accepted = 0;
    int  item_count = 0;
    bit  drain_marked = 1'b0;
    logic char_taken = 1'b0;
    logic long_stall = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;
    rx_mode_t rx_mode = RX_OPEN;
    int  rx_mode_left = 0;
    int  rx_phase = 0;

    base64_stream_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .text_char  (text_char),
        .final_char (final_char),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic logic [7:0] char_of_sextet(input logic [5:0] v);
        if (v < 6'd26) return 8'h41 + v;
        if (v < 6'd52) return 8'h61 + (v - 6'd26);
        if (v < 6'd62) return 8'h30 + (v - 6'd52);
        if (v == 6'd62) return 8'h2B;
        return 8'h2F;
    endfunction

    // Advance the predicted quartet state by one character
    function automatic void decode_char(input logic [7:0] c, input logic last,
                                        output logic has_byte, output logic [7:0] b);
        logic [5:0] s;
        s = sextet_lut[c];
        has_byte = 1'b0;
        b = 8'h00;
        if (skip_next) begin
            skip_next = 1'b0;
            quartet_pos = 2'd0;
        end else begin
            case (quartet_pos)
                2'd0: begin
                    if (c != CHR_CR && c != CHR_LF) begin
                        held_sextet = s;
                        quartet_pos = 2'd1;
                    end
                end
                2'd1: begin
                    b = {held_sextet, s[5:4]};
                    has_byte = 1'b1;
                    held_sextet = s;
                    quartet_pos = 2'd2;
                end
                2'd2: begin
                    if (c == CHR_PAD) begin
                        skip_next = 1'b1;
                        quartet_pos = 2'd3;
                    end else begin
                        b = {held_sextet[3:0], s[5:2]};
                        has_byte = 1'b1;
                        held_sextet = s;
                        quartet_pos = 2'd3;
                    end
                end
                default: begin
                    if (c != CHR_PAD) begin
                        b = {held_sextet[1:0], s};
                        has_byte = 1'b1;
                    end
                    quartet_pos = 2'd0;
                end
            endcase
        end
        // final mark returns to quartet start
        if (last) begin
            quartet_pos = 2'd0;
            held_sextet = 6'd0;
            skip_next = 1'b0;
        end
    endfunction

    task automatic push_char(input logic [7:0] c, input logic last, input logic drain);
        text_item_t item;
        item.ch = c;
        item.last = last;
        item.wait_drain = drain;
        pending_chars.push_back(item);
        if (c != CHR_CR && c != CHR_LF) item_count++;
    endtask

    // Encode a random message and queue its text, optionally damaged
    task automatic queue_message(input logic mark_end, input logic drain);
        logic [7:0] txt[$];
        logic [23:0] grp;
        int nbytes;
        int n;
        int cut;
        bit drop_pad;
        nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        drop_pad = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < nbytes; i += 3) begin
            n = (nbytes - i >= 3) ? 3 : nbytes - i;
            grp = {8'($urandom), 8'($urandom), 8'($urandom)};
            if (n < 3) grp[7:0] = 8'h00;
            if (n < 2) grp[15:8] = 8'h00;
            // line break only between full quartets
            if (i > 0 && $urandom_range(0, 4) == 0) begin
                if ($urandom_range(0, 1)) txt.push_back(CHR_CR);
                txt.push_back(CHR_LF);
            end
            txt.push_back(char_of_sextet(grp[23:18]));
            txt.push_back(char_of_sextet(grp[17:12]));
            if (n >= 2) txt.push_back(char_of_sextet(grp[11:6]));
            else if (!drop_pad) txt.push_back(CHR_PAD);
            if (n == 3) txt.push_back(char_of_sextet(grp[5:0]));
            else if (!drop_pad) txt.push_back(CHR_PAD);
        end
        // broken sequence: lose a tail
        if ($urandom_range(0, 9) == 0 && txt.size() > 2) begin
            cut = $urandom_range(1, 2);
            repeat (cut) void'(txt.pop_back());
        end
        foreach (txt[k]) begin
            push_char(txt[k], (k == txt.size() - 1) ? mark_end : 1'b0, (k == 0) ? drain : 1'b0);
        end
    endtask

    // Watch both channels: predict on accepted characters, check accepted bytes
    always @(posedge clk) begin : watch_channels
        logic       has_byte;
        logic [7:0] b;
        logic [7:0] want;
        if (!rst_n) begin
            char_taken <= 1'b0;
        end else begin
            char_taken <= in_valid && in_ready;
            if (in_valid && in_ready) begin
                decode_char(text_char, final_char, has_byte, b);
                if (has_byte) expected_bytes.push_back(b);
                chars_accepted++;
            end
            if (out_valid && out_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("byte %02h with none expected", out_byte));
                end else begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want)
                        report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want));
                end
            end
        end
    end

    // Offer characters in bursts with random gaps
    always @(negedge clk) begin : drive_chars
        logic       offer;
        text_item_t item;
        if (rst_n) begin
            offer = in_valid && !char_taken;
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_chars.size() > 0 &&
                             !(pending_chars[0].wait_drain && expected_bytes.size() != 0)) begin
                    item = pending_chars.pop_front();
                    text_char <= item.ch;
                    final_char <= item.last;
                    offer = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end
            end
            in_valid <= offer;
        end
    end

    // Stall the output on a changing pattern
    always @(negedge clk) begin : drive_ready
        logic ready;
        if (rx_mode_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 150);
        end else begin
            rx_mode_left--;
        end
        rx_phase++;
        case (rx_mode)
            RX_OPEN:     ready = 1'b1;
            RX_COIN:     ready = 1'($urandom_range(0, 1));
            RX_SPARSE:   ready = ($urandom_range(0, 3) == 0);
            default:     ready = (rx_phase % 3 == 0);
        endcase
        out_ready <= ready && !long_stall;
    end

    // Hold off the receiver long enough to back up the input
    initial begin : hold_off
        wait (chars_accepted >= HOLD_OFF_AFTER);
        @(negedge clk);
        long_stall <= 1'b1;
        repeat (LONG_STALL_CYCLES) @(negedge clk);
        long_stall <= 1'b0;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : main_seq
        logic [7:0] noise_len;
        for (int i = 0; i < 256; i++) sextet_lut[i] = 6'd0;
        for (int v = 0; v < 64; v++) sextet_lut[char_of_sextet(6'(v))] = 6'(v);

        // alphabet extremes
        push_char("A", 1'b0, 1'b0);
        push_char("Z", 1'b0, 1'b0);
        push_char("a", 1'b0, 1'b0);
        push_char("z", 1'b0, 1'b0);
        push_char("0", 1'b0, 1'b0);
        push_char("9", 1'b0, 1'b0);
        push_char("+", 1'b0, 1'b0);
        push_char("/", 1'b0, 1'b0);
        // line breaks skipped at quartet start, decoded as zero elsewhere; out-of-range codes
        push_char(CHR_CR, 1'b0, 1'b0);
        push_char(CHR_LF, 1'b0, 1'b0);
        push_char(8'h00, 1'b0, 1'b0);
        push_char(CHR_CR, 1'b0, 1'b0);
        push_char(8'hFF, 1'b0, 1'b0);
        push_char(CHR_LF, 1'b0, 1'b0);
        // pad in first and second position decodes as zero, pad in third skips the fourth
        push_char(CHR_PAD, 1'b0, 1'b0);
        push_char(CHR_PAD, 1'b0, 1'b0);
        push_char(CHR_PAD, 1'b0, 1'b0);
        push_char("x", 1'b0, 1'b0);
        // pad in fourth position
        push_char("T", 1'b0, 1'b0);
        push_char("W", 1'b0, 1'b0);
        push_char("E", 1'b0, 1'b0);
        push_char(CHR_PAD, 1'b0, 1'b0);
        // final mark in mid quartet
        push_char("S", 1'b0, 1'b0);
        push_char("G", 1'b1, 1'b0);

        // random part: mostly encoded messages, some noise
        while (item_count < RANDOM_ITEMS + 24) begin
            if ($urandom_range(0, 4) != 0) begin
                queue_message($urandom_range(0, 9) < 7,
                              !drain_marked && item_count >= DRAIN_MARK_AT);
                if (item_count >= DRAIN_MARK_AT) drain_marked = 1'b1;
            end else begin
                noise_len = 8'($urandom_range(1, 8));
                repeat (noise_len) push_char(8'($urandom), ($urandom_range(0, 3) == 0), 1'b0);
            end
        end

        // reset once
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for all text to go in and all bytes to come out
        while (pending_chars.size() != 0 || in_valid || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_bytes.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
